/* rtl/core/polyline_rect_clipper_defines.svh */
// Assertion macros used by the polyline_rect_clipper datapath.
// Depends on nothing; the using module must have i_clk and i_rst_n.
`ifndef POLYLINE_RECT_CLIPPER_DEFINES_SVH
`define POLYLINE_RECT_CLIPPER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define PCR_AST_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define PCR_AST_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/pcr_pkg.sv */
// Shared types and constants of the polyline rectangle clipper.
// Depends on nothing; every RTL module of the block imports it.
package pcr_pkg;

    localparam int CB    = 32;          // coordinate bits
    localparam int DW    = CB + 1;      // coordinate difference bits
    localparam int PW    = 2 * DW;      // product bits
    localparam int MAXO  = 16;          // result buffer depth per stage
    localparam int IW    = $clog2(MAXO);
    localparam int CW    = IW + 1;      // counts up to MAXO

    localparam logic [1:0] PC_EMPTY = 2'd0;
    localparam logic [1:0] PC_HELD  = 2'd1;
    localparam logic [1:0] PC_EMIT  = 2'd2;

    typedef enum logic [1:0] {EDGE_S, EDGE_E, EDGE_N, EDGE_W} t_edge;

    typedef enum logic [1:0] {CFG_X_MIN, CFG_Y_MIN, CFG_X_MAX, CFG_Y_MAX} t_cfg_idx;

    typedef struct packed {
        logic signed [CB-1:0] pt_x;
        logic signed [CB-1:0] pt_y;
        logic                 polyline_end;
    } t_in;

    typedef struct packed {
        logic signed [CB-1:0] out_x;
        logic signed [CB-1:0] out_y;
        logic                 piece_end;
        logic                 run_last;
    } t_out;

    typedef struct packed {
        logic signed [CB-1:0] x;
        logic signed [CB-1:0] y;
        logic                 last;
    } t_vtx;

    typedef enum logic [3:0] {
        ST_IDLE, ST_LOAD, ST_EVAL, ST_DIV, ST_PUTX, ST_PUTP,
        ST_CLOSE, ST_FIN, ST_ORD, ST_OSHOW
    } t_state;

    typedef enum logic [1:0] {MD_IDLE, MD_MUL, MD_DIV} t_md_phase;

    typedef struct packed {
        logic load_in;
        logic rd;
        logic div_go;
        logic put;
        logic put_sel_p;
        logic close;
        logic fin;
        logic out_adv;
    } t_cmd;

    typedef struct packed {
        logic ins;
        logic need_x;
        logic held_one;
        logic div_done;
        logic last_item;
        logic last_stage;
        logic next_empty;
        logic out_last;
    } t_sts;

endpackage

/* rtl/core/polyline_rect_clipper.sv */
// Top level of the polyline rectangle clipper.
// Depends on pcr_pkg, pcr_ctrl and pcr_datapath.
//
// Usage: vertices enter on the input channel (i_in_valid / o_in_stall) as
// t_in items; a transfer happens on a rising edge with valid high and stall
// low. Clipped vertices leave on the output channel (o_out_valid /
// i_out_stall) as t_out items. The window is set through the plain write
// port (i_cfg_we, i_cfg_idx, i_cfg_data) while the block is idle.
// One vertex is worked on at a time; o_in_stall is high during reset and
// from the transfer until its work ends and any last result has been taken.
// Order of work: the edge stages S, E, N, W run in turn over the vertices
// in their buffers. A stage loads a vertex, evaluates it, puts any points
// and finishes it; an edge crossing adds a divider run (shift-add
// multiply steps, divide steps and a handover) and further put and close
// steps. Each result is read from the buffer and then shown on the output.
// Reset clears the window to zero, marks every edge stage inside with no
// point seen and no piece open, and empties the output.
// When the receiver stalls, the current result holds steady on the output
// and the block waits; no state advances until the transfer completes.
module polyline_rect_clipper import pcr_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  t_in           i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output t_out          o_out_data,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_idx,
    input  logic [CB-1:0] i_cfg_data
);

    // Commands from the sequencer and status back from the datapath.
    t_cmd cmd;
    t_sts sts;

    pcr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    pcr_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_out      (o_out_data)
    );

endmodule

/* rtl/core/pcr_muldiv.sv */
// Sequential signed trunc(a*b/d): shift-add multiply, then restoring divide.
// Depends on pcr_pkg.
module pcr_muldiv import pcr_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [DW-1:0] i_a,
    input  logic signed [DW-1:0] i_b,
    input  logic signed [DW-1:0] i_d,
    output logic                 o_done,
    output logic signed [DW-1:0] o_q
);

    localparam int KW = $clog2(PW + 1);

    t_md_phase        r_phase, n_phase;
    logic [KW-1:0]    r_k;
    logic             r_done;
    logic             r_neg;
    logic             r_dz;
    logic [PW-1:0]    r_acc;
    logic [PW-1:0]    r_mc;
    logic [DW-1:0]    r_mp;
    logic [DW-1:0]    r_ud;
    logic [DW-1:0]    r_rem;
    logic [DW-1:0]    r_qt;
    logic signed [DW-1:0] r_q;

    logic [DW:0]      trial;
    logic             fits;
    logic [DW-1:0]    n_rem;
    logic [DW-1:0]    n_qt;

    always_comb begin
        trial = {r_rem, r_acc[PW-1]};
        fits  = trial >= {1'b0, r_ud};
        n_rem = fits ? DW'(trial - {1'b0, r_ud}) : trial[DW-1:0];
        n_qt  = {r_qt[DW-2:0], fits};
    end

    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            MD_IDLE: begin
                if (i_start) begin
                    n_phase = MD_MUL;
                end
            end
            MD_MUL: begin
                if (r_k == KW'(DW - 1)) begin
                    n_phase = MD_DIV;
                end
            end
            MD_DIV: begin
                if (r_k == KW'(PW - 1)) begin
                    n_phase = MD_IDLE;
                end
            end
            default: n_phase = MD_IDLE;
        endcase
    end

    // The step counter restarts at every phase change.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= MD_IDLE;
            r_k     <= '0;
            r_done  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_done  <= (r_phase == MD_DIV) && (r_k == KW'(PW - 1));
            r_k     <= (n_phase != r_phase || r_phase == MD_IDLE) ? '0 : KW'(r_k + 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_phase)
            MD_IDLE: begin
                r_acc <= '0;
                r_mc  <= PW'(i_a[DW-1] ? DW'(-i_a) : DW'(i_a));
                r_mp  <= i_b[DW-1] ? DW'(-i_b) : DW'(i_b);
                r_ud  <= i_d[DW-1] ? DW'(-i_d) : DW'(i_d);
                r_neg <= i_a[DW-1] ^ i_b[DW-1] ^ i_d[DW-1];
                r_dz  <= i_d == '0;
                r_rem <= '0;
                r_qt  <= '0;
            end
            MD_MUL: begin
                if (r_mp[0]) begin
                    r_acc <= r_acc + r_mc;
                end
                r_mc <= {r_mc[PW-2:0], 1'b0};
                r_mp <= {1'b0, r_mp[DW-1:1]};
            end
            MD_DIV: begin
                r_acc <= {r_acc[PW-2:0], 1'b0};
                r_rem <= n_rem;
                r_qt  <= n_qt;
                if (r_k == KW'(PW - 1)) begin
                    r_q <= r_dz ? '0 : (r_neg ? DW'(-n_qt) : DW'(n_qt));
                end
            end
            default: ;
        endcase
    end

    assign o_done = r_done;
    assign o_q    = r_q;

endmodule

/* rtl/core/pcr_datapath.sv */
// Clipper datapath: window registers, per-edge state, stage buffers and divider.
// Depends on pcr_pkg, pcr_muldiv and the assertion macros header.
`include "polyline_rect_clipper_defines.svh"
module pcr_datapath import pcr_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_in           i_in,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_idx,
    input  logic [CB-1:0] i_cfg_data,
    input  t_cmd          i_cmd,
    output t_sts          o_sts,
    output t_out          o_out
);

    function automatic logic signed [DW-1:0] sx(input logic signed [CB-1:0] v);
        return {v[CB-1], v};
    endfunction

    logic signed [CB-1:0] r_xmin, r_ymin, r_xmax, r_ymax;
    logic [3:0]           r_inside;
    logic [3:0]           r_seen;
    logic [1:0]           r_cnt   [4];
    logic signed [CB-1:0] r_prevx [4];
    logic signed [CB-1:0] r_prevy [4];
    logic signed [CB-1:0] r_heldx [4];
    logic signed [CB-1:0] r_heldy [4];
    t_edge                r_s;
    logic [CW-1:0]        r_i, r_n, r_m;
    logic                 r_bank;
    logic signed [CB-1:0] r_bufx [2*MAXO];
    logic signed [CB-1:0] r_bufy [2*MAXO];
    logic [2*MAXO-1:0]    r_bend;
    t_vtx                 r_p;
    t_out                 r_out;

    logic signed [DW-1:0] win_a, side_b;
    logic                 ins;
    logic signed [CB-1:0] e_val, base;
    logic signed [DW-1:0] md_a, md_b, md_d;
    logic signed [DW-1:0] q;
    logic                 div_done;
    logic signed [CB-1:0] sum;
    t_vtx                 cross_v, p_v, put_v, push_v;
    logic                 push_en, close_en, room, out_last, last_item;
    logic [1:0]           cur_cnt;
    logic [IW:0]          ra, wa, ca;
    logic [CW-1:0]        m_dec;

    assign cur_cnt = r_cnt[r_s];

    // Inside test: sign of the edge vector against the point's offset.
    always_comb begin
        win_a  = (r_s == EDGE_S || r_s == EDGE_N) ? DW'(sx(r_xmax) - sx(r_xmin))
                                                  : DW'(sx(r_ymax) - sx(r_ymin));
        unique case (r_s)
            EDGE_S: side_b = DW'(sx(r_p.y) - sx(r_ymin));
            EDGE_E: side_b = DW'(sx(r_xmax) - sx(r_p.x));
            EDGE_N: side_b = DW'(sx(r_ymax) - sx(r_p.y));
            default: side_b = DW'(sx(r_p.x) - sx(r_xmin));
        endcase
        ins = (win_a == '0) || (side_b == '0) || (win_a[DW-1] == side_b[DW-1]);
    end

    // Crossing operands and the resulting point.
    always_comb begin
        unique case (r_s)
            EDGE_S: e_val = r_ymin;
            EDGE_E: e_val = r_xmax;
            EDGE_N: e_val = r_ymax;
            default: e_val = r_xmin;
        endcase
        if (r_s == EDGE_S || r_s == EDGE_N) begin
            md_a = DW'(sx(e_val) - sx(r_prevy[r_s]));
            md_b = DW'(sx(r_p.x) - sx(r_prevx[r_s]));
            md_d = DW'(sx(r_p.y) - sx(r_prevy[r_s]));
            base = r_prevx[r_s];
        end else begin
            md_a = DW'(sx(e_val) - sx(r_prevx[r_s]));
            md_b = DW'(sx(r_p.y) - sx(r_prevy[r_s]));
            md_d = DW'(sx(r_p.x) - sx(r_prevx[r_s]));
            base = r_prevy[r_s];
        end
        sum = base + q[CB-1:0];
        if (r_s == EDGE_S || r_s == EDGE_N) begin
            cross_v = '{x: sum, y: e_val, last: 1'b0};
        end else begin
            cross_v = '{x: e_val, y: sum, last: 1'b0};
        end
    end

    pcr_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_go),
        .i_a     (md_a),
        .i_b     (md_b),
        .i_d     (md_d),
        .o_done  (div_done),
        .o_q     (q)
    );

    // Piece bookkeeping: the first point of a piece is held back.
    always_comb begin
        p_v     = '{x: r_p.x, y: r_p.y, last: 1'b0};
        put_v   = i_cmd.put_sel_p ? p_v : cross_v;
        push_v  = put_v;
        push_en = 1'b0;
        if (i_cmd.put) begin
            unique case (cur_cnt)
                PC_EMPTY: push_en = 1'b0;
                PC_HELD: begin
                    push_en = 1'b1;
                    push_v  = '{x: r_heldx[r_s], y: r_heldy[r_s], last: 1'b0};
                end
                default: push_en = 1'b1;
            endcase
        end
        close_en  = i_cmd.close || (i_cmd.fin && r_p.last);
        room      = r_m < CW'(MAXO);
        m_dec     = r_m - 1'b1;
        ra        = {r_bank, r_i[IW-1:0]};
        wa        = {~r_bank, r_m[IW-1:0]};
        ca        = {~r_bank, m_dec[IW-1:0]};
        last_item = r_i == r_n - 1'b1;
        out_last  = last_item;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_bufx[{r_bank, IW'(0)}] <= i_in.pt_x;
            r_bufy[{r_bank, IW'(0)}] <= i_in.pt_y;
            r_bend[{r_bank, IW'(0)}] <= i_in.polyline_end;
        end
        if (push_en && room) begin
            r_bufx[wa] <= push_v.x;
            r_bufy[wa] <= push_v.y;
            r_bend[wa] <= 1'b0;
        end
        if (close_en && cur_cnt == PC_EMIT && r_m != '0) begin
            r_bend[ca] <= 1'b1;
        end
        if (i_cmd.put && cur_cnt == PC_EMPTY) begin
            r_heldx[r_s] <= put_v.x;
            r_heldy[r_s] <= put_v.y;
        end
        if (i_cmd.rd) begin
            r_p   <= '{x: r_bufx[ra], y: r_bufy[ra], last: r_bend[ra]};
            r_out <= '{out_x: r_bufx[ra], out_y: r_bufy[ra], piece_end: r_bend[ra],
                       run_last: out_last};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xmin   <= '0;
            r_ymin   <= '0;
            r_xmax   <= '0;
            r_ymax   <= '0;
            r_inside <= '1;
            r_seen   <= '0;
            for (int k = 0; k < 4; k++) begin
                r_cnt[k]   <= PC_EMPTY;
                r_prevx[k] <= '0;
                r_prevy[k] <= '0;
            end
            r_s    <= EDGE_S;
            r_i    <= '0;
            r_n    <= '0;
            r_m    <= '0;
            r_bank <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_X_MIN: r_xmin <= i_cfg_data;
                    CFG_Y_MIN: r_ymin <= i_cfg_data;
                    CFG_X_MAX: r_xmax <= i_cfg_data;
                    CFG_Y_MAX: r_ymax <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.load_in) begin
                r_n <= CW'(1);
                r_m <= '0;
                r_i <= '0;
                r_s <= EDGE_S;
            end
            if (push_en && room) begin
                r_m <= r_m + 1'b1;
            end
            if (i_cmd.put) begin
                unique case (cur_cnt)
                    PC_EMPTY: r_cnt[r_s] <= PC_HELD;
                    PC_HELD:  r_cnt[r_s] <= PC_EMIT;
                    default:  r_cnt[r_s] <= cur_cnt;
                endcase
            end
            if (close_en) begin
                r_cnt[r_s] <= PC_EMPTY;
            end
            if (i_cmd.fin) begin
                r_prevx[r_s]  <= r_p.x;
                r_prevy[r_s]  <= r_p.y;
                r_inside[r_s] <= r_p.last | ins;
                r_seen[r_s]   <= ~r_p.last;
                if (last_item) begin
                    r_bank <= ~r_bank;
                    r_n    <= r_m;
                    r_m    <= '0;
                    r_i    <= '0;
                    r_s    <= t_edge'(r_s + 1'b1);
                end else begin
                    r_i <= r_i + 1'b1;
                end
            end
            if (i_cmd.out_adv) begin
                r_i <= r_i + 1'b1;
            end
        end
    end

    always_comb begin
        o_sts.ins        = ins;
        o_sts.need_x     = r_seen[r_s] && (ins ? !r_inside[r_s] : r_inside[r_s]);
        o_sts.held_one   = cur_cnt == PC_HELD;
        o_sts.div_done   = div_done;
        o_sts.last_item  = last_item;
        o_sts.last_stage = r_s == EDGE_W;
        o_sts.next_empty = r_m == '0;
        o_sts.out_last   = out_last;
    end

    assign o_out = r_out;

    `PCR_AST_IMP(a_cnt_code, 1'b1, cur_cnt != 2'd3, "piece count holds an unused code")
    `PCR_AST_IMP(a_fill_bound, 1'b1, r_m <= CW'(MAXO) && r_n <= CW'(MAXO), "buffer count overrun")
    `PCR_AST_NXT(a_div_latency, i_cmd.div_go, !div_done, "divider finished right after start")
    `PCR_AST_NXT(a_load_one, i_cmd.load_in, r_n == CW'(1) && r_s == EDGE_S, "bad load of input")

endmodule

/* rtl/core/pcr_ctrl.sv */
// Clipper controller: sequences each vertex through edge stages S to W.
// Depends on pcr_pkg.
module pcr_ctrl import pcr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    output logic o_out_valid,
    input  logic i_out_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_stall  = (r_state != ST_IDLE) || !i_rst_n;
        o_out_valid = r_state == ST_OSHOW;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid && i_rst_n) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = ST_LOAD;
                end
            end
            ST_LOAD: begin
                o_cmd.rd = 1'b1;
                n_state  = ST_EVAL;
            end
            ST_EVAL: begin
                priority if (i_sts.need_x) begin
                    o_cmd.div_go = 1'b1;
                    n_state      = ST_DIV;
                end else if (i_sts.ins) begin
                    n_state = ST_PUTP;
                end else begin
                    n_state = ST_FIN;
                end
            end
            ST_DIV: begin
                if (i_sts.div_done) begin
                    n_state = ST_PUTX;
                end
            end
            ST_PUTX: begin
                o_cmd.put = 1'b1;
                if (!i_sts.held_one) begin
                    n_state = i_sts.ins ? ST_PUTP : ST_CLOSE;
                end
            end
            ST_PUTP: begin
                o_cmd.put       = 1'b1;
                o_cmd.put_sel_p = 1'b1;
                if (!i_sts.held_one) begin
                    n_state = ST_FIN;
                end
            end
            ST_CLOSE: begin
                o_cmd.close = 1'b1;
                n_state     = ST_FIN;
            end
            ST_FIN: begin
                o_cmd.fin = 1'b1;
                priority if (!i_sts.last_item) begin
                    n_state = ST_LOAD;
                end else if (i_sts.next_empty) begin
                    n_state = ST_IDLE;
                end else if (i_sts.last_stage) begin
                    n_state = ST_ORD;
                end else begin
                    n_state = ST_LOAD;
                end
            end
            ST_ORD: begin
                o_cmd.rd = 1'b1;
                n_state  = ST_OSHOW;
            end
            ST_OSHOW: begin
                if (!i_out_stall) begin
                    o_cmd.out_adv = 1'b1;
                    n_state       = i_sts.out_last ? ST_IDLE : ST_ORD;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

/* tb/polyline_rect_clipper_tb.sv */
// Testbench for the polyline rectangle clipper: directed and random polylines
// are checked against a predictor of the edge-by-edge clipping pipeline.
// Depends on pcr_pkg and the polyline_rect_clipper RTL.
`timescale 1ns / 100ps

import pcr_pkg::*;

// Scoreboard: keeps its own copy of the window and the per-edge state, works
// out the clipped vertices for every accepted vertex and checks each result.
class clip_scoreboard;
    typedef struct {
        longint x;
        longint y;
        bit     term;
    } t_pt;

    longint win[4];                 // indexed by t_cfg_idx
    bit     inside_q[4];
    longint prev_x[4], prev_y[4];
    longint held_x[4], held_y[4];
    int     piece_cnt[4];
    bit     seen_pt[4];
    t_out   expected_vtx[$];
    int     errors;

    function new();
        for (int s = 0; s < 4; s++) begin
            win[s] = 0;
            inside_q[s] = 1;
            prev_x[s] = 0;
            prev_y[s] = 0;
            held_x[s] = 0;
            held_y[s] = 0;
            piece_cnt[s] = 0;
            seen_pt[s] = 0;
        end
        errors = 0;
    endfunction

    function void set_window(t_cfg_idx idx, logic [CB-1:0] val);
        win[idx] = longint'($signed(val));
    endfunction

    // A point is inside when the cross product against the directed edge is
    // not negative; a zero-length edge keeps every point inside.
    function bit on_inner_side(int s, longint x, longint y);
        longint a, b;
        case (s)
            EDGE_S: begin a = win[CFG_X_MAX] - win[CFG_X_MIN]; b = y - win[CFG_Y_MIN]; end
            EDGE_E: begin a = win[CFG_Y_MAX] - win[CFG_Y_MIN]; b = win[CFG_X_MAX] - x; end
            EDGE_N: begin a = win[CFG_X_MAX] - win[CFG_X_MIN]; b = win[CFG_Y_MAX] - y; end
            default: begin a = win[CFG_Y_MAX] - win[CFG_Y_MIN]; b = x - win[CFG_X_MIN]; end
        endcase
        if (a == 0 || b == 0) return 1;
        return (a > 0) == (b > 0);
    endfunction

    // Exact wide product, quotient truncated toward zero, zero divisor gives 0.
    function longint scaled_quot(longint a, longint b, longint d);
        logic signed [127:0] p;
        logic signed [127:0] q;
        if (d == 0) return 0;
        p = 128'(signed'(a)) * 128'(signed'(b));
        q = p / 128'(signed'(d));
        return longint'(q);
    endfunction

    function void edge_cut(int s, longint x1, longint y1, longint x2, longint y2,
                           output longint ox, output longint oy);
        longint e;
        if (s == EDGE_S || s == EDGE_N) begin
            e = (s == EDGE_S) ? win[CFG_Y_MIN] : win[CFG_Y_MAX];
            ox = x1 + scaled_quot(e - y1, x2 - x1, y2 - y1);
            oy = e;
        end else begin
            e = (s == EDGE_E) ? win[CFG_X_MAX] : win[CFG_X_MIN];
            ox = e;
            oy = y1 + scaled_quot(e - x1, y2 - y1, x2 - x1);
        end
    endfunction

    function void add_pt(ref t_pt o[$], longint x, longint y);
        t_pt v;
        v.x = x;
        v.y = y;
        v.term = 0;
        if (o.size() < MAXO) o = {o, v};
    endfunction

    // The first point of a piece is held back until a second one arrives.
    function void emit(int s, longint x, longint y, ref t_pt o[$]);
        if (piece_cnt[s] == 0) begin
            held_x[s] = x;
            held_y[s] = y;
            piece_cnt[s] = 1;
            return;
        end
        if (piece_cnt[s] == 1) begin
            add_pt(o, held_x[s], held_y[s]);
            piece_cnt[s] = 2;
        end
        add_pt(o, x, y);
    endfunction

    function void close_piece(int s, ref t_pt o[$]);
        if (piece_cnt[s] >= 2 && o.size() > 0) o[o.size() - 1].term = 1;
        piece_cnt[s] = 0;
    endfunction

    function void run_edge(int s, t_pt p, ref t_pt o[$]);
        longint ix, iy;
        if (on_inner_side(s, p.x, p.y)) begin
            if (!inside_q[s] && seen_pt[s]) begin
                edge_cut(s, prev_x[s], prev_y[s], p.x, p.y, ix, iy);
                emit(s, ix, iy, o);
            end
            emit(s, p.x, p.y, o);
            inside_q[s] = 1;
        end else begin
            if (inside_q[s] && seen_pt[s]) begin
                edge_cut(s, prev_x[s], prev_y[s], p.x, p.y, ix, iy);
                emit(s, ix, iy, o);
                close_piece(s, o);
            end
            inside_q[s] = 0;
        end
        prev_x[s] = p.x;
        prev_y[s] = p.y;
        seen_pt[s] = 1;
        if (p.term) begin
            close_piece(s, o);
            inside_q[s] = 1;
            seen_pt[s] = 0;
        end
    endfunction

    function void note_vertex(t_in v);
        t_pt  cur[$];
        t_pt  nxt[$];
        t_pt  p;
        t_out r;
        p.x = longint'(v.pt_x);
        p.y = longint'(v.pt_y);
        p.term = v.polyline_end;
        cur = {p};
        for (int s = 0; s < 4; s++) begin
            nxt.delete();
            foreach (cur[i]) run_edge(s, cur[i], nxt);
            cur = nxt;
        end
        foreach (cur[i]) begin
            r.out_x = cur[i].x[CB-1:0];
            r.out_y = cur[i].y[CB-1:0];
            r.piece_end = cur[i].term;
            r.run_last = (i == cur.size() - 1);
            expected_vtx = {expected_vtx, r};
        end
    endfunction

    function void check_result(t_out got);
        t_out want;
        if (expected_vtx.size() == 0) begin
            $error("unexpected result x=%0d y=%0d", got.out_x, got.out_y);
            errors++;
            return;
        end
        want = expected_vtx.pop_front();
        if (got.out_x !== want.out_x) begin
            $error("out_x expected %0d actual %0d", want.out_x, got.out_x);
            errors++;
        end
        if (got.out_y !== want.out_y) begin
            $error("out_y expected %0d actual %0d", want.out_y, got.out_y);
            errors++;
        end
        if (got.piece_end !== want.piece_end) begin
            $error("piece_end expected %0b actual %0b", want.piece_end, got.piece_end);
            errors++;
        end
        if (got.run_last !== want.run_last) begin
            $error("run_last expected %0b actual %0b", want.run_last, got.run_last);
            errors++;
        end
    endfunction
endclass

module polyline_rect_clipper_tb;

    localparam int  CYCLE_LIMIT   = 20000000;
    localparam int  MIN32         = -2147483647 - 1;
    localparam int  MAX32         = 2147483647;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_in_valid;
    logic          o_in_stall;
    t_in           i_in_data;
    logic          o_out_valid;
    logic          i_out_stall;
    t_out          o_out_data;
    logic          i_cfg_we;
    logic [1:0]    i_cfg_idx;
    logic [CB-1:0] i_cfg_data;

    clip_scoreboard clip_sb;
    int             cycle_cnt;
    bit             hold_request;     // asks the receiver for a long hold-off

    polyline_rect_clipper DUT (.*);

    // 8 ns clock.
    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Every accepted input transfer goes into the predictor at the same edge
    // at which the block takes it.
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) clip_sb.note_vertex(i_in_data);
    end

    // Every accepted output transfer is checked against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) clip_sb.check_result(o_out_data);
    end

    // Receiver: changes its stall mode at random intervals, from never
    // stalling to stalling most of the time. A hold request forces one long
    // stretch of stall so the block backs up and stalls its input.
    int rx_mode;
    int rx_mode_left;
    int rx_hold_left;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall  <= 1'b0;
            rx_mode      <= 0;
            rx_mode_left <= 0;
            rx_hold_left <= 0;
        end else if (hold_request && rx_hold_left == 0) begin
            rx_hold_left <= 600;
            i_out_stall  <= 1'b1;
        end else if (rx_hold_left > 1) begin
            rx_hold_left <= rx_hold_left - 1;
            i_out_stall  <= 1'b1;
        end else begin
            if (rx_hold_left == 1) rx_hold_left <= hold_request ? 1 : 0;
            if (rx_mode_left == 0) begin
                rx_mode      <= $urandom_range(0, 2);
                rx_mode_left <= $urandom_range(10, 80);
            end else begin
                rx_mode_left <= rx_mode_left - 1;
            end
            case (rx_mode)
                0:       i_out_stall <= 1'b0;
                1:       i_out_stall <= ($urandom_range(0, 99) < 30);
                default: i_out_stall <= ($urandom_range(0, 99) < 85);
            endcase
        end
    end

    // Offers one vertex and waits for its transfer. Valid stays high after
    // the transfer; the gap task lowers it.
    task automatic send_vertex(int x, int y, bit last);
        i_in_valid <= 1'b1;
        i_in_data.pt_x <= x;
        i_in_data.pt_y <= y;
        i_in_data.polyline_end <= last;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic idle_sender(int cycles);
        i_in_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Sender bursts: after every vertex the burst may end with a random gap.
    int burst_left;
    task automatic paced_vertex(int x, int y, bit last);
        send_vertex(x, y, last);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 25);
            if ($urandom_range(0, 1)) idle_sender($urandom_range(1, 12));
        end
    endtask

    // Waits for every expected result, then for the block to go idle, which
    // covers work that causes no result, so that the window can be changed.
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (clip_sb.expected_vtx.size() != 0) @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic write_window(int xlo, int ylo, int xhi, int yhi);
        int vals[4];
        vals = '{xlo, ylo, xhi, yhi};
        for (int i = 0; i < 4; i++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= i[1:0];
            i_cfg_data <= vals[i];
            @(posedge i_clk);
            clip_sb.set_window(t_cfg_idx'(i), vals[i]);
        end
        i_cfg_we <= 1'b0;
    endtask

    // Random coordinate: mostly near the window so that crossings happen,
    // sometimes a fully random word so that every bit toggles.
    function automatic int pick_coord(int lo, int hi);
        longint a, b, span;
        a = (lo < hi) ? lo : hi;
        b = (lo < hi) ? hi : lo;
        span = b - a + 1;
        case ($urandom_range(0, 9))
            0, 1:    return $urandom();
            2:       return $urandom_range(0, 1) ? a : b;
            default: begin
                longint v;
                v = a - span / 2 + longint'({$urandom(), $urandom()} % (2 * span));
                if (v > MAX32) v = MAX32;
                if (v < MIN32) v = MIN32;
                return int'(v);
            end
        endcase
    endfunction

    task automatic random_polylines(int n_items, int xlo, int ylo, int xhi, int yhi);
        int left;
        int len;
        left = n_items;
        while (left > 0) begin
            // Most polylines are a few vertices long; some are lone points.
            len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 8);
            for (int k = 0; k < len && left > 0; k++) begin
                paced_vertex(pick_coord(xlo, xhi), pick_coord(ylo, yhi),
                             (k == len - 1) || (left == 1));
                left--;
            end
        end
    endtask

    initial begin
        clip_sb      = new();
        cycle_cnt    = 0;
        hold_request = 1'b0;
        burst_left   = 0;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= '0;
        i_cfg_data  <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: a small square window.
        write_window(-100, -100, 100, 100);
        send_vertex(0, 0, 0);                  // inside
        send_vertex(MAX32, 0, 0);              // leaves through the east edge
        send_vertex(100, 50, 0);               // enters through a point on the edge
        send_vertex(MIN32, MIN32, 0);          // leaves through a corner region
        send_vertex(MAX32, MAX32, 0);          // crosses the whole window
        send_vertex(-50, 20, 1);               // ends the polyline inside
        send_vertex(5, 5, 1);                  // lone point is dropped
        send_vertex(MIN32, 0, 0);              // starts outside the west edge
        send_vertex(MAX32, 0, 1);              // crosses west and east
        send_vertex(0, MAX32, 0);
        send_vertex(0, MIN32, 0);
        send_vertex(-100, -100, 0);
        send_vertex(100, 100, 1);
        drain();

        // Directed: degenerate window, every point is inside every edge.
        write_window(7, 7, 7, 7);
        send_vertex(MIN32, MAX32, 0);
        send_vertex(MAX32, MIN32, 0);
        send_vertex(0, 0, 1);
        drain();

        // Directed: inverted window flips the inside half-planes.
        write_window(100, 100, -100, -100);
        send_vertex(0, 0, 0);
        send_vertex(500, 500, 0);
        send_vertex(-500, 20, 1);
        drain();

        // Random phases over several windows, the extremes among them.
        write_window(-1000, -1000, 1000, 1000);
        random_polylines(80, -1000, -1000, 1000, 1000);
        drain();

        write_window(MIN32, MIN32, MAX32, MAX32);
        random_polylines(50, MIN32, MIN32, MAX32, MAX32);
        drain();

        write_window(-3, 20, 40, 25);
        hold_request = 1'b1;                   // long receiver hold-off here
        random_polylines(70, -3, 20, 40, 25);
        hold_request = 1'b0;
        drain();

        write_window(300, 300, -300, -300);
        random_polylines(50, -300, -300, 300, 300);
        drain();

        write_window(0, -50, 0, 50);
        random_polylines(30, -50, -50, 50, 50);
        drain();

        write_window($urandom(), $urandom(), $urandom(), $urandom());
        random_polylines(40, MIN32, MIN32, MAX32, MAX32);
        drain();

        write_window(-20000, -5000, 60000, 90000);
        random_polylines(80, -20000, -5000, 60000, 90000);
        drain();

        if (clip_sb.errors == 0 && clip_sb.expected_vtx.size() == 0) begin
            $display("== PASS ==");
        end else begin
            if (clip_sb.expected_vtx.size() != 0)
                $error("%0d expected results never arrived", clip_sb.expected_vtx.size());
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
